// ===== design/rpp_pkg.sv =====
// ----------------------------------------------------------------------------
// rpp_pkg
// Shared types and constants for the route report parser.
// ----------------------------------------------------------------------------
package rpp_pkg;

  localparam logic [7:0] MASK_TOP_BYTE = 8'hFF;
  localparam int unsigned TDATA_W = 72;  // origin + mask + metric, padded to bytes

  // Message status codes
  typedef enum logic [1:0] {
    STATUS_CONTINUES = 2'd0,
    STATUS_CLEAN_END = 2'd1,
    STATUS_TRUNCATED = 2'd2
  } msg_status_t;

  // One result record
  typedef struct packed {
    logic        route_valid;
    logic [31:0] origin;
    logic [31:0] mask;
    logic [6:0]  metric;
    logic        group_end;
    msg_status_t message_status;
  } route_rec_t;

endpackage

// ===== design/rpp_parse.sv =====
// ----------------------------------------------------------------------------
// rpp_parse
// Input register and parse state: turns one payload byte into at most one
// route record per cycle while room is high.
// ----------------------------------------------------------------------------
module rpp_parse
  import rpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_data,
  input  logic       in_last,
  output logic       in_ready,
  input  logic       room,
  output logic       res_valid,
  output route_rec_t res
);

  typedef enum logic [1:0] {
    PH_MASK   = 2'd0,
    PH_ORIGIN = 2'd1,
    PH_METRIC = 2'd2
  } phase_t;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_last;

  // Parse state
  phase_t      phase, phase_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [23:0] mask_low_bytes, mask_low_bytes_next;
  logic [2:0]  origin_width, origin_width_next;
  logic [31:0] origin_accum, origin_accum_next;

  logic       fire;
  logic       is_metric;
  logic [2:0] index_plus_one;

  assign in_ready = !s1_valid || room;
  assign fire     = s1_valid && room;

  // Capture the next byte whenever the input register frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_data <= in_data;
      s1_last <= in_last;
    end
  end

  assign index_plus_one = {1'b0, byte_index} + 3'd1;
  assign is_metric      = (phase == PH_METRIC);

  // Next state and result for the byte in the input register
  always_comb begin
    phase_next          = phase;
    byte_index_next     = byte_index;
    mask_low_bytes_next = mask_low_bytes;
    origin_width_next   = origin_width;
    origin_accum_next   = origin_accum;
    res                 = '0;
    res.message_status  = STATUS_CONTINUES;

    unique case (phase)
      PH_ORIGIN: begin
        // place the byte big-endian from the top
        unique case (byte_index)
          2'd0: origin_accum_next[31:24] = origin_accum[31:24] | s1_data;
          2'd1: origin_accum_next[23:16] = origin_accum[23:16] | s1_data;
          2'd2: origin_accum_next[15:8]  = origin_accum[15:8]  | s1_data;
          default: origin_accum_next[7:0] = origin_accum[7:0] | s1_data;
        endcase
        if (index_plus_one >= origin_width) begin
          phase_next      = PH_METRIC;
          byte_index_next = 2'd0;
        end else begin
          byte_index_next = index_plus_one[1:0];
        end
      end
      PH_METRIC: begin
        res.route_valid = 1'b1;
        res.origin      = origin_accum;
        res.mask        = {MASK_TOP_BYTE, mask_low_bytes};
        res.metric      = s1_data[6:0];
        res.group_end   = s1_data[7];
        if (s1_last) begin
          res.message_status = s1_data[7] ? STATUS_CLEAN_END : STATUS_TRUNCATED;
        end
        if (s1_data[7]) begin
          phase_next      = PH_MASK;
          byte_index_next = 2'd0;
        end else begin
          phase_next        = PH_ORIGIN;
          byte_index_next   = 2'd0;
          origin_accum_next = '0;
        end
      end
      default: begin
        // mask bytes, unused code treated the same
        mask_low_bytes_next = {mask_low_bytes[15:0], s1_data};
        if (byte_index >= 2'd2) begin
          if (s1_data != 8'd0) begin
            origin_width_next = 3'd4;
          end else if (mask_low_bytes[7:0] != 8'd0) begin
            origin_width_next = 3'd3;
          end else if (mask_low_bytes[15:8] != 8'd0) begin
            origin_width_next = 3'd2;
          end else begin
            origin_width_next = 3'd1;
          end
          phase_next        = PH_ORIGIN;
          byte_index_next   = 2'd0;
          origin_accum_next = '0;
        end else begin
          phase_next      = PH_MASK;
          byte_index_next = index_plus_one[1:0];
        end
      end
    endcase

    // End of message: report truncation on a non-metric byte, then clear
    if (s1_last) begin
      if (!is_metric) begin
        res                = '0;
        res.message_status = STATUS_TRUNCATED;
      end
      phase_next          = PH_MASK;
      byte_index_next     = 2'd0;
      mask_low_bytes_next = '0;
      origin_width_next   = 3'd1;
      origin_accum_next   = '0;
    end
  end

  assign res_valid = fire && (is_metric || s1_last);

  // Hold parse state, advance on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_MASK;
      byte_index     <= 2'd0;
      mask_low_bytes <= '0;
      origin_width   <= 3'd1;
      origin_accum   <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      byte_index     <= byte_index_next;
      mask_low_bytes <= mask_low_bytes_next;
      origin_width   <= origin_width_next;
      origin_accum   <= origin_accum_next;
    end
  end

endmodule

// ===== design/rpp_out_buf.sv =====
// ----------------------------------------------------------------------------
// rpp_out_buf
// Two-entry result buffer: registers each record and decouples the parser
// from output backpressure.
// ----------------------------------------------------------------------------
module rpp_out_buf
  import rpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  route_rec_t push_rec,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output route_rec_t out_rec
);

  route_rec_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign room      = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_rec   = entry[rd_ptr];

  // Store records
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_rec;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/route_report_parser.sv =====
// ----------------------------------------------------------------------------
// route_report_parser
// Parses the payload of a multicast distance-vector route report into route
// records.
// ----------------------------------------------------------------------------
// Takes one payload byte per cycle on the slave side while s_tready is high
// (s_tlast on a message's last byte) and emits one record per (origin,
// metric) pair, plus one record with tuser route_valid low when a message ends
// on a byte that is not a metric byte. Sustained rate is one byte per clock
// while m_tready is high; a byte's record passes the input register and the
// output buffer. The two-entry output buffer keeps s_tready a function of
// registers only; after m_tready drops, input flows until the buffer fills.
module route_report_parser
  import rpp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] data_byte
  input  logic               s_tlast,   // last_byte
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [31:0] origin, [63:32] mask,
                                        // [70:64] metric, [71] zero
  output logic               m_tlast,   // group_end
  output logic [2:0]         m_tuser    // [0] route_valid, [2:1] message_status
);

  logic       room;
  logic       res_valid;
  route_rec_t res;
  route_rec_t out_rec;

  rpp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_data   (s_tdata),
    .in_last   (s_tlast),
    .in_ready  (s_tready),
    .room      (room),
    .res_valid (res_valid),
    .res       (res)
  );

  rpp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_rec  (res),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rec   (out_rec)
  );

  // Pack the record onto the master side
  assign m_tdata = {1'b0, out_rec.metric, out_rec.mask, out_rec.origin};
  assign m_tlast = out_rec.group_end;
  assign m_tuser = {out_rec.message_status, out_rec.route_valid};

endmodule
